>>> rtl/fmsp_pkg.sv
// fmsp_pkg: types, codes and masks for the file mode string parser
// no dependencies; used by the interfaces, the step logic and the top level
package fmsp_pkg;

  localparam int unsigned ModeW = 12;
  localparam int unsigned CharW = 8;

  // ascii codes
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChSeven = 8'h37;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChEq    = 8'h3D;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChU     = 8'h75;
  localparam logic [CharW-1:0] ChG     = 8'h67;
  localparam logic [CharW-1:0] ChO     = 8'h6F;
  localparam logic [CharW-1:0] ChA     = 8'h61;
  localparam logic [CharW-1:0] ChR     = 8'h72;
  localparam logic [CharW-1:0] ChW     = 8'h77;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] ChS     = 8'h73;
  localparam logic [CharW-1:0] ChT     = 8'h74;

  // who and permission masks
  localparam logic [ModeW-1:0] MaskAll  = 12'o7777;
  localparam logic [ModeW-1:0] MaskUser = 12'o5700;
  localparam logic [ModeW-1:0] MaskGrp  = 12'o3070;
  localparam logic [ModeW-1:0] MaskOth  = 12'o1007;
  localparam logic [ModeW-1:0] MaskRd   = 12'o0444;
  localparam logic [ModeW-1:0] MaskWr   = 12'o0222;
  localparam logic [ModeW-1:0] MaskEx   = 12'o0111;
  localparam logic [ModeW-1:0] MaskSid  = 12'o6000;
  localparam logic [ModeW-1:0] MaskStk  = 12'o1000;

  typedef enum logic [2:0] {
    PhStart = 3'b001,
    PhWho   = 3'b010,
    PhPerm  = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    OpSet = 2'd0,
    OpClr = 2'd1,
    OpAdd = 2'd2,
    OpBad = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadNum = 2'd1,
    StBadOp  = 2'd2,
    StNoOp   = 2'd3
  } status_e;

  typedef struct packed {
    phase_e           phase;
    logic [ModeW-1:0] mode;
    logic [ModeW-1:0] who;
    logic [ModeW-1:0] perm;
    op_e              op;
    logic             numeric;
    status_e          err;
  } state_t;

  localparam state_t StateReset = '{
    phase:   PhStart,
    mode:    '0,
    who:     '0,
    perm:    '0,
    op:      OpSet,
    numeric: 1'b0,
    err:     StOk
  };

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             first;
    logic             last;
    logic [ModeW-1:0] start_mode;
  } item_t;

  typedef struct packed {
    logic [ModeW-1:0] new_mode;
    status_e          status;
  } result_t;

endpackage

>>> rtl/fmsp_if.sv
// fmsp_if: valid/ready channels for mode string characters and results
// depends on fmsp_pkg
interface fmsp_in_if;
  logic                         valid;
  logic                         ready;
  logic [fmsp_pkg::CharW-1:0]   ch;
  logic                         first;
  logic                         last;
  logic [fmsp_pkg::ModeW-1:0]   start_mode;

  modport source (output valid, ch, first, last, start_mode, input ready);
  modport sink   (input valid, ch, first, last, start_mode, output ready);
endinterface

interface fmsp_out_if;
  logic                         valid;
  logic                         ready;
  logic [fmsp_pkg::ModeW-1:0]   new_mode;
  logic [1:0]                   status;

  modport source (output valid, new_mode, status, input ready);
  modport sink   (input valid, new_mode, status, output ready);
endinterface

>>> rtl/fmsp_step.sv
// fmsp_step: next parse state and result for one character
// depends on fmsp_pkg
module fmsp_step (
  input  fmsp_pkg::state_t  state_i,
  input  fmsp_pkg::item_t   item_i,
  output fmsp_pkg::state_t  state_o,
  output fmsp_pkg::result_t res_o
);

  function automatic logic [fmsp_pkg::ModeW-1:0] who_mask(input logic [fmsp_pkg::CharW-1:0] c);
    logic [fmsp_pkg::ModeW-1:0] m;
    begin
      m = '0;
      if (c == fmsp_pkg::ChU) m = fmsp_pkg::MaskUser;
      if (c == fmsp_pkg::ChG) m = fmsp_pkg::MaskGrp;
      if (c == fmsp_pkg::ChO) m = fmsp_pkg::MaskOth;
      if (c == fmsp_pkg::ChA) m = fmsp_pkg::MaskAll;
      return m;
    end
  endfunction

  function automatic logic [fmsp_pkg::ModeW-1:0] perm_mask(input logic [fmsp_pkg::CharW-1:0] c);
    logic [fmsp_pkg::ModeW-1:0] m;
    begin
      m = '0;
      if (c == fmsp_pkg::ChR) m = fmsp_pkg::MaskRd;
      if (c == fmsp_pkg::ChW) m = fmsp_pkg::MaskWr;
      if (c == fmsp_pkg::ChX) m = fmsp_pkg::MaskEx;
      if (c == fmsp_pkg::ChS) m = fmsp_pkg::MaskSid;
      if (c == fmsp_pkg::ChT) m = fmsp_pkg::MaskStk;
      return m;
    end
  endfunction

  function automatic logic [fmsp_pkg::ModeW-1:0] apply_clause(input fmsp_pkg::state_t s);
    logic [fmsp_pkg::ModeW-1:0] w;
    logic [fmsp_pkg::ModeW-1:0] e;
    logic [fmsp_pkg::ModeW-1:0] m;
    begin
      w = (s.who != '0) ? s.who : fmsp_pkg::MaskAll;
      e = w & s.perm;
      m = s.mode;
      case (s.op)
        fmsp_pkg::OpSet: m = (s.mode & ~w) | e;
        fmsp_pkg::OpClr: m = s.mode & ~e;
        fmsp_pkg::OpAdd: m = s.mode | e;
        default:         m = s.mode;
      endcase
      return m;
    end
  endfunction

  fmsp_pkg::state_t           st;
  logic                       is_oct;
  logic [fmsp_pkg::ModeW-1:0] who_m;
  logic [fmsp_pkg::ModeW-1:0] perm_m;
  logic                       perm_taken;

  always_comb begin
    st         = state_i;
    is_oct     = (item_i.ch >= fmsp_pkg::ChZero) && (item_i.ch <= fmsp_pkg::ChSeven);
    who_m      = who_mask(item_i.ch);
    perm_m     = perm_mask(item_i.ch);
    perm_taken = 1'b0;

    if (item_i.first) begin
      st         = fmsp_pkg::StateReset;
      st.numeric = is_oct;
      st.mode    = is_oct ? '0 : item_i.start_mode;
    end

    if (st.err == fmsp_pkg::StOk) begin
      if (st.numeric) begin
        // overflow once the top digit is occupied
        if (!is_oct || (st.mode[fmsp_pkg::ModeW-1 -: 3] != 3'd0)) begin
          st.err = fmsp_pkg::StBadNum;
        end else begin
          st.mode = {st.mode[fmsp_pkg::ModeW-4:0], item_i.ch[2:0]};
        end
      end else begin
        if (st.phase == fmsp_pkg::PhPerm) begin
          if (perm_m != '0) begin
            st.perm    = st.perm | perm_m;
            perm_taken = 1'b1;
          end else begin
            // non-permission char closes the clause
            st.mode  = apply_clause(st);
            st.phase = fmsp_pkg::PhStart;
            st.who   = '0;
            st.perm  = '0;
            st.op    = fmsp_pkg::OpSet;
          end
        end
        if (!perm_taken && !(st.phase == fmsp_pkg::PhStart && item_i.ch == fmsp_pkg::ChComma))
        begin
          if (who_m != '0) begin
            st.who   = st.who | who_m;
            st.phase = fmsp_pkg::PhWho;
          end else begin
            st.phase = fmsp_pkg::PhPerm;
            if (item_i.ch == fmsp_pkg::ChEq) begin
              st.op = fmsp_pkg::OpSet;
            end else if (item_i.ch == fmsp_pkg::ChMinus) begin
              st.op = fmsp_pkg::OpClr;
            end else if (item_i.ch == fmsp_pkg::ChPlus) begin
              st.op = fmsp_pkg::OpAdd;
            end else begin
              st.op  = fmsp_pkg::OpBad;
              st.err = fmsp_pkg::StBadOp;
            end
          end
        end
      end
    end

    state_o = st;

    if (st.err != fmsp_pkg::StOk) begin
      res_o.new_mode = '0;
      res_o.status   = st.err;
    end else if (st.numeric) begin
      res_o.new_mode = st.mode;
      res_o.status   = fmsp_pkg::StOk;
    end else if (st.phase != fmsp_pkg::PhPerm) begin
      res_o.new_mode = '0;
      res_o.status   = fmsp_pkg::StNoOp;
    end else begin
      res_o.new_mode = apply_clause(st);
      res_o.status   = fmsp_pkg::StOk;
    end
  end

endmodule

>>> rtl/file_mode_string_parser_unit.sv
// file_mode_string_parser_unit: applies an octal or symbolic mode string to a file mode
// a last word waits in the input reg; its result is registered once the output is free
// throughput: one character word per cycle; the input stalls only while a last word
// waits behind a result that is not being taken
// reset: asynchronous, clears parse state and both valid flags; start_mode seeds symbolic
// depends on fmsp_pkg, fmsp_if, fmsp_step
module file_mode_string_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fmsp_in_if.sink    in_i,
  fmsp_out_if.source out_o
);

  fmsp_pkg::item_t   item_q;
  logic              in_vld_q;
  fmsp_pkg::state_t  state_q;
  fmsp_pkg::state_t  state_d;
  fmsp_pkg::result_t res_d;
  fmsp_pkg::result_t res_q;
  logic              out_vld_q;

  logic out_free;
  logic adv;
  logic in_acc;

  assign out_free  = !out_vld_q || out_o.ready;
  assign adv       = in_vld_q && (!item_q.last || out_free);
  assign in_i.ready = !in_vld_q || adv;
  assign in_acc    = in_i.valid && in_i.ready;

  fmsp_step u_step (
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= '{ch: in_i.ch, first: in_i.first, last: in_i.last,
                  start_mode: in_i.start_mode};
    end
    if (adv && item_q.last) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= fmsp_pkg::StateReset;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        state_q <= state_d;
      end
      if (adv && item_q.last) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.new_mode = res_q.new_mode;
  assign out_o.status   = res_q.status;

endmodule

>>> rtl/fmsp_checker.sv
// fmsp_checker: port-level checks for file_mode_string_parser_unit
// depends on fmsp_pkg; bound to the top level below
module fmsp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [fmsp_pkg::ModeW-1:0] out_new_mode_i,
  input logic [1:0]                 out_status_i
);

  // last words taken but not yet delivered
  logic [1:0] pend_q;
  logic       in_last_acc;
  logic       out_acc;

  assign in_last_acc = in_valid_i && in_ready_i && in_last_i;
  assign out_acc     = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_last_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (!in_last_acc && out_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_new_mode_i)
                                    && $stable(out_status_i))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != fmsp_pkg::StOk) |-> out_new_mode_i == '0)
    else $error("error result carries a nonzero mode");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a blocked result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without an accepted last word");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two results outstanding");

endmodule

bind file_mode_string_parser_unit fmsp_checker u_fmsp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_last_i      (in_i.last),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_new_mode_i (out_o.new_mode),
  .out_status_i   (out_o.status)
);
